[rtl/tsnb_pkg.sv]
package tsnb_pkg;

    // magnitudes kept for the length estimate
    localparam int KEEP_BITS = 30;
    // square root of a sum of three squares of KEEP_BITS values
    localparam int SUM_W     = 2 * KEEP_BITS + 2;
    localparam int ROOT_W    = SUM_W / 2;

    // stage counts of the fixed-latency front units
    localparam int CROSS_LAT = 6;
    localparam int SCALE_LAT = 4;

    // pipeline advance and upstream valid
    typedef struct packed {
        logic en;
        logic valid;
    } pipe_ctl_t;

    // scaled cross product magnitudes with their signs
    typedef struct packed {
        logic [2:0][KEEP_BITS-1:0] mag;
        logic [2:0]                neg;
    } scaled_t;

endpackage

[rtl/tsnb_cross.sv]
module tsnb_cross #(
    parameter int CW = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  tsnb_pkg::pipe_ctl_t        ctl,
    input  logic [2:0][CW-1:0]         p0,
    input  logic [2:0][CW-1:0]         p1,
    input  logic [2:0][CW-1:0]         p2,
    output logic                       valid,
    output logic [2:0][2*CW:0]         mag,
    output logic [2:0]                 neg
);

    localparam int HW  = (CW + 1) / 2;
    localparam int PPW = 2 * HW;
    localparam int ACW = 4 * HW;
    localparam int PW  = 2 * CW;
    localparam int SW  = PW + 1;
    localparam int AIX [6] = '{1, 2, 2, 0, 0, 1};
    localparam int BIX [6] = '{2, 1, 0, 2, 1, 0};

    logic [tsnb_pkg::CROSS_LAT-1:0] vld_reg;

    logic [2:0][CW-1:0]    ma_reg, ma_next, mb_reg, mb_next;
    logic [2:0]            sa_reg, sa_next, sb_reg, sb_next;
    logic [PPW-1:0]        pp_reg [6][4];
    logic [PPW-1:0]        pp_next [6][4];
    logic [5:0]            ps2_reg, ps2_next, ps3_reg;
    logic [PW-1:0]         pm_reg [6];
    logic [PW-1:0]         pm_next [6];
    logic signed [SW-1:0]  sp_reg [6];
    logic signed [SW-1:0]  sp_next [6];
    logic signed [SW:0]    c_reg [3];
    logic signed [SW:0]    c_next [3];
    logic [2:0][SW-1:0]    mag_reg, mag_next;
    logic [2:0]            neg_reg, neg_next;

    // edges and their magnitudes
    always_comb
    begin
        logic signed [CW:0] ea, eb;
        for (int i = 0; i < 3; i++)
        begin
            ea = $signed({p1[i][CW-1], p1[i]}) - $signed({p0[i][CW-1], p0[i]});
            eb = $signed({p2[i][CW-1], p2[i]}) - $signed({p0[i][CW-1], p0[i]});
            sa_next[i] = ea[CW];
            sb_next[i] = eb[CW];
            ma_next[i] = ea[CW] ? CW'(-ea) : ea[CW-1:0];
            mb_next[i] = eb[CW] ? CW'(-eb) : eb[CW-1:0];
        end
    end

    // partial products of the low and high operand halves of each edge product
    always_comb
    begin
        logic [PPW-1:0] al, ah, bl, bh;
        for (int j = 0; j < 6; j++)
        begin
            al = PPW'(ma_reg[AIX[j]][HW-1:0]);
            ah = PPW'(ma_reg[AIX[j]][CW-1:HW]);
            bl = PPW'(mb_reg[BIX[j]][HW-1:0]);
            bh = PPW'(mb_reg[BIX[j]][CW-1:HW]);
            pp_next[j][0] = al * bl;
            pp_next[j][1] = al * bh;
            pp_next[j][2] = ah * bl;
            pp_next[j][3] = ah * bh;
            ps2_next[j] = sa_reg[AIX[j]] ^ sb_reg[BIX[j]];
        end
    end

    // partial product sum
    always_comb
    begin
        logic [ACW-1:0] acc;
        for (int j = 0; j < 6; j++)
        begin
            acc = (ACW'(pp_reg[j][3]) << (2 * HW))
                + ((ACW'(pp_reg[j][1]) + ACW'(pp_reg[j][2])) << HW)
                + ACW'(pp_reg[j][0]);
            pm_next[j] = acc[PW-1:0];
        end
    end

    // signed products, cross differences, magnitudes
    always_comb
    begin
        for (int j = 0; j < 6; j++)
        begin
            sp_next[j] = ps3_reg[j] ? -$signed({1'b0, pm_reg[j]}) : $signed({1'b0, pm_reg[j]});
        end
        for (int k = 0; k < 3; k++)
        begin
            c_next[k] = $signed({sp_reg[2*k][SW-1], sp_reg[2*k]})
                      - $signed({sp_reg[2*k+1][SW-1], sp_reg[2*k+1]});
            neg_next[k] = c_reg[k][SW];
            mag_next[k] = c_reg[k][SW] ? SW'(-c_reg[k]) : c_reg[k][SW-1:0];
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (ctl.en)
        begin
            vld_reg <= {vld_reg[tsnb_pkg::CROSS_LAT-2:0], ctl.valid};
        end
    end

    // data stages
    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            ma_reg   <= ma_next;
            mb_reg   <= mb_next;
            sa_reg   <= sa_next;
            sb_reg   <= sb_next;
            pp_reg   <= pp_next;
            ps2_reg  <= ps2_next;
            pm_reg   <= pm_next;
            ps3_reg  <= ps2_reg;
            sp_reg   <= sp_next;
            c_reg    <= c_next;
            mag_reg  <= mag_next;
            neg_reg  <= neg_next;
        end
    end

    assign valid = vld_reg[tsnb_pkg::CROSS_LAT-1];
    assign mag   = mag_reg;
    assign neg   = neg_reg;

endmodule

[rtl/tsnb_scale.sv]
module tsnb_scale #(
    parameter int CW = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  tsnb_pkg::pipe_ctl_t                 ctl,
    input  logic [2:0][2*CW:0]                  mag,
    input  logic [2:0]                          neg,
    output logic                                valid,
    output tsnb_pkg::scaled_t                   scaled,
    output logic [tsnb_pkg::SUM_W-1:0]          sum
);

    localparam int CMW = 2 * CW + 1;
    localparam int LW  = $clog2(CMW + 1);
    localparam int KB  = tsnb_pkg::KEEP_BITS;
    localparam int QW  = 2 * KB;

    logic [tsnb_pkg::SCALE_LAT-1:0] vld_reg;

    logic [2:0][CMW-1:0]      mag_reg;
    logic [2:0]               neg_reg;
    logic [LW-1:0]            sh_reg, sh_next;
    tsnb_pkg::scaled_t        sc2_reg, sc2_next, sc3_reg, sc4_reg;
    logic [2:0][QW-1:0]       sq_reg, sq_next;
    logic [tsnb_pkg::SUM_W-1:0] sum_reg, sum_next;

    // bit length of the largest magnitude, shift down to KEEP_BITS
    always_comb
    begin
        logic [CMW-1:0] orv;
        logic [LW-1:0]  blen;
        orv  = mag[0] | mag[1] | mag[2];
        blen = '0;
        for (int b = 0; b < CMW; b++)
        begin
            if (orv[b])
            begin
                blen = LW'(b + 1);
            end
        end
        sh_next = (blen > LW'(KB)) ? blen - LW'(KB) : '0;
    end

    // shifted magnitudes, squares, sum
    always_comb
    begin
        logic [CMW-1:0] shv;
        for (int i = 0; i < 3; i++)
        begin
            shv = mag_reg[i] >> sh_reg;
            sc2_next.mag[i] = shv[KB-1:0];
            sq_next[i] = QW'(sc2_reg.mag[i]) * QW'(sc2_reg.mag[i]);
        end
        sc2_next.neg = neg_reg;
        sum_next = tsnb_pkg::SUM_W'(sq_reg[0]) + tsnb_pkg::SUM_W'(sq_reg[1])
                 + tsnb_pkg::SUM_W'(sq_reg[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (ctl.en)
        begin
            vld_reg <= {vld_reg[tsnb_pkg::SCALE_LAT-2:0], ctl.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            mag_reg <= mag;
            neg_reg <= neg;
            sh_reg  <= sh_next;
            sc2_reg <= sc2_next;
            sq_reg  <= sq_next;
            sc3_reg <= sc2_reg;
            sum_reg <= sum_next;
            sc4_reg <= sc3_reg;
        end
    end

    assign valid  = vld_reg[tsnb_pkg::SCALE_LAT-1];
    assign scaled = sc4_reg;
    assign sum    = sum_reg;

endmodule

[rtl/tsnb_sqrt.sv]
module tsnb_sqrt (
    input  logic                              clk,
    input  logic                              rst_n,
    input  tsnb_pkg::pipe_ctl_t               ctl,
    input  tsnb_pkg::scaled_t                 scaled_in,
    input  logic [tsnb_pkg::SUM_W-1:0]        sum,
    output logic                              valid,
    output tsnb_pkg::scaled_t                 scaled_out,
    output logic [tsnb_pkg::ROOT_W-1:0]       root
);

    localparam int RN = tsnb_pkg::ROOT_W;
    localparam int SW = tsnb_pkg::SUM_W;
    localparam int RW = RN + 3;

    logic [RN-1:0]      vld_reg;
    logic [RW-1:0]      rem_reg  [RN];
    logic [RN-1:0]      root_reg [RN];
    logic [SW-1:0]      val_reg  [RN];
    tsnb_pkg::scaled_t  sc_reg   [RN];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (ctl.en)
        begin
            vld_reg <= {vld_reg[RN-2:0], ctl.valid};
        end
    end

    // one result bit per stage, two radicand bits consumed
    for (genvar s = 0; s < RN; s++)
    begin : g_stage
        logic [RW-1:0]     rem_prev, rem_next;
        logic [RN-1:0]     root_prev, root_next;
        logic [SW-1:0]     val_prev;
        tsnb_pkg::scaled_t sc_prev;

        if (s == 0)
        begin : g_first
            assign rem_prev  = '0;
            assign root_prev = '0;
            assign val_prev  = sum;
            assign sc_prev   = scaled_in;
        end
        else
        begin : g_next
            assign rem_prev  = rem_reg[s-1];
            assign root_prev = root_reg[s-1];
            assign val_prev  = val_reg[s-1];
            assign sc_prev   = sc_reg[s-1];
        end

        always_comb
        begin
            logic [RW-1:0] trial, test;
            trial = {rem_prev[RW-3:0], val_prev[SW-1:SW-2]};
            test  = {1'b0, root_prev, 2'b01};
            if (trial >= test)
            begin
                rem_next  = trial - test;
                root_next = {root_prev[RN-2:0], 1'b1};
            end
            else
            begin
                rem_next  = trial;
                root_next = {root_prev[RN-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            if (ctl.en)
            begin
                rem_reg[s]  <= rem_next;
                root_reg[s] <= root_next;
                val_reg[s]  <= {val_prev[SW-3:0], 2'b00};
                sc_reg[s]   <= sc_prev;
            end
        end
    end

    assign valid      = vld_reg[RN-1];
    assign scaled_out = sc_reg[RN-1];
    assign root       = root_reg[RN-1];

endmodule

[rtl/tsnb_div.sv]
module tsnb_div #(
    parameter int NW = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  tsnb_pkg::pipe_ctl_t              ctl,
    input  tsnb_pkg::scaled_t                scaled,
    input  logic [tsnb_pkg::ROOT_W-1:0]      len,
    output logic                             valid,
    output logic [2:0][NW-1:0]               normal
);

    localparam int F   = NW - 2;
    localparam int QW  = F + 1;
    localparam int LN  = tsnb_pkg::ROOT_W;
    localparam int RMW = LN + F + 1;
    localparam int LAT = QW + 2;

    logic [LAT-1:0]        vld_reg;

    // numerator setup
    logic [2:0][RMW-1:0]   n_reg, n_next;
    logic [LN-1:0]         l0_reg;
    logic [2:0]            ng0_reg;
    logic                  lz0_reg;

    // long division stages
    logic [2:0][RMW-1:0]   rem_reg  [QW];
    logic [2:0][QW-1:0]    q_reg    [QW];
    logic [LN-1:0]         l_reg    [QW];
    logic [2:0]            ng_reg   [QW];
    logic                  lz_reg   [QW];

    logic [2:0][NW-1:0]    nrm_reg, nrm_next;

    // mag * 2^F + len / 2, rounds the quotient half away from zero
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            n_next[i] = (RMW'(scaled.mag[i]) << F) + RMW'(len >> 1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (ctl.en)
        begin
            vld_reg <= {vld_reg[LAT-2:0], ctl.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            n_reg   <= n_next;
            l0_reg  <= len;
            ng0_reg <= scaled.neg;
            lz0_reg <= (len == '0);
        end
    end

    for (genvar j = 0; j < QW; j++)
    begin : g_stage
        logic [2:0][RMW-1:0] rem_prev, rem_next;
        logic [2:0][QW-1:0]  q_prev, q_next;
        logic [LN-1:0]       l_prev;
        logic [2:0]          ng_prev;
        logic                lz_prev;

        if (j == 0)
        begin : g_first
            assign rem_prev = n_reg;
            assign q_prev   = '0;
            assign l_prev   = l0_reg;
            assign ng_prev  = ng0_reg;
            assign lz_prev  = lz0_reg;
        end
        else
        begin : g_next
            assign rem_prev = rem_reg[j-1];
            assign q_prev   = q_reg[j-1];
            assign l_prev   = l_reg[j-1];
            assign ng_prev  = ng_reg[j-1];
            assign lz_prev  = lz_reg[j-1];
        end

        // quotient bit F - j
        always_comb
        begin
            logic [RMW-1:0] d;
            d = RMW'(l_prev) << (F - j);
            for (int i = 0; i < 3; i++)
            begin
                if (rem_prev[i] >= d)
                begin
                    rem_next[i] = rem_prev[i] - d;
                    q_next[i]   = {q_prev[i][QW-2:0], 1'b1};
                end
                else
                begin
                    rem_next[i] = rem_prev[i];
                    q_next[i]   = {q_prev[i][QW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (ctl.en)
            begin
                rem_reg[j] <= rem_next;
                q_reg[j]   <= q_next;
                l_reg[j]   <= l_prev;
                ng_reg[j]  <= ng_prev;
                lz_reg[j]  <= lz_prev;
            end
        end
    end

    // clamp to one, zero for a degenerate triangle, apply sign
    always_comb
    begin
        logic [QW-1:0] q;
        for (int i = 0; i < 3; i++)
        begin
            q = q_reg[QW-1][i];
            if (lz_reg[QW-1])
            begin
                q = '0;
            end
            else if (q > (QW'(1) << F))
            begin
                q = QW'(1) << F;
            end
            nrm_next[i] = ng_reg[QW-1][i] ? -NW'(q) : NW'(q);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            nrm_reg <= nrm_next;
        end
    end

    assign valid  = vld_reg[LAT-1];
    assign normal = nrm_reg;

endmodule

[rtl/triangle_setup_normal_bbox.sv]
// channel   handshake            payload
// tri       tri_valid/tri_stall  vert0_x .. vert2_z, three vertices
// res       res_valid/res_stall  ref_x/y/z, normal_x/y/z, box_min/max_x/y/z
//
// one triangle per cycle while tri_stall is low; the pipeline is made of the
// cross product multiplier stages, the scaling stages, the 31-stage square
// root, the one-bit-per-stage normal divider and the output register
// reset clears the valid bits only
// a stalled result sits in the output register, one more goes to a skid
// register, then tri_stall rises and the whole pipeline holds
module triangle_setup_normal_bbox #(
    parameter int COORD_WIDTH  = 32,
    parameter int NORMAL_WIDTH = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            tri_valid,
    output logic                            tri_stall,
    input  logic signed [COORD_WIDTH-1:0]   vert0_x,
    input  logic signed [COORD_WIDTH-1:0]   vert0_y,
    input  logic signed [COORD_WIDTH-1:0]   vert0_z,
    input  logic signed [COORD_WIDTH-1:0]   vert1_x,
    input  logic signed [COORD_WIDTH-1:0]   vert1_y,
    input  logic signed [COORD_WIDTH-1:0]   vert1_z,
    input  logic signed [COORD_WIDTH-1:0]   vert2_x,
    input  logic signed [COORD_WIDTH-1:0]   vert2_y,
    input  logic signed [COORD_WIDTH-1:0]   vert2_z,
    output logic                            res_valid,
    input  logic                            res_stall,
    output logic signed [COORD_WIDTH-1:0]   ref_x,
    output logic signed [COORD_WIDTH-1:0]   ref_y,
    output logic signed [COORD_WIDTH-1:0]   ref_z,
    output logic signed [NORMAL_WIDTH-1:0]  normal_x,
    output logic signed [NORMAL_WIDTH-1:0]  normal_y,
    output logic signed [NORMAL_WIDTH-1:0]  normal_z,
    output logic signed [COORD_WIDTH-1:0]   box_min_x,
    output logic signed [COORD_WIDTH-1:0]   box_min_y,
    output logic signed [COORD_WIDTH-1:0]   box_min_z,
    output logic signed [COORD_WIDTH-1:0]   box_max_x,
    output logic signed [COORD_WIDTH-1:0]   box_max_y,
    output logic signed [COORD_WIDTH-1:0]   box_max_z
);

    localparam int CW  = COORD_WIDTH;
    localparam int NW  = NORMAL_WIDTH;
    localparam int LAT = tsnb_pkg::CROSS_LAT + tsnb_pkg::SCALE_LAT
                       + tsnb_pkg::ROOT_W + NW + 1;
    localparam int SUMW = CW + 2;

    logic                        en;
    tsnb_pkg::pipe_ctl_t         cross_ctl, scale_ctl, sqrt_ctl, div_ctl;
    logic [2:0][CW-1:0]          p0, p1, p2;

    logic                        cross_valid;
    logic [2:0][2*CW:0]          cross_mag;
    logic [2:0]                  cross_neg;
    logic                        scale_valid;
    tsnb_pkg::scaled_t           scale_sc, sqrt_sc;
    logic [tsnb_pkg::SUM_W-1:0]  scale_sum;
    logic                        sqrt_valid;
    logic [tsnb_pkg::ROOT_W-1:0] sqrt_root;
    logic                        div_valid;
    logic [2:0][NW-1:0]          div_normal;

    // reference point and box travel beside the normal
    logic [8:0][CW-1:0]          side_next;
    logic [8:0][CW-1:0]          side_reg [LAT];

    logic                        out_valid_reg, skid_valid_reg;
    logic [2:0][NW-1:0]          out_nrm_reg, skid_nrm_reg;
    logic [8:0][CW-1:0]          out_side_reg, skid_side_reg;

    assign en = !skid_valid_reg;
    assign tri_stall = skid_valid_reg;

    assign p0 = {vert0_z, vert0_y, vert0_x};
    assign p1 = {vert1_z, vert1_y, vert1_x};
    assign p2 = {vert2_z, vert2_y, vert2_x};

    assign cross_ctl = '{en: en, valid: tri_valid};
    assign scale_ctl = '{en: en, valid: cross_valid};
    assign sqrt_ctl  = '{en: en, valid: scale_valid};
    assign div_ctl   = '{en: en, valid: sqrt_valid};

    tsnb_cross #(.CW(CW)) u_cross (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (cross_ctl),
        .p0    (p0),
        .p1    (p1),
        .p2    (p2),
        .valid (cross_valid),
        .mag   (cross_mag),
        .neg   (cross_neg)
    );

    tsnb_scale #(.CW(CW)) u_scale (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (scale_ctl),
        .mag    (cross_mag),
        .neg    (cross_neg),
        .valid  (scale_valid),
        .scaled (scale_sc),
        .sum    (scale_sum)
    );

    tsnb_sqrt u_sqrt (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (sqrt_ctl),
        .scaled_in  (scale_sc),
        .sum        (scale_sum),
        .valid      (sqrt_valid),
        .scaled_out (sqrt_sc),
        .root       (sqrt_root)
    );

    tsnb_div #(.NW(NW)) u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (div_ctl),
        .scaled (sqrt_sc),
        .len    (sqrt_root),
        .valid  (div_valid),
        .normal (div_normal)
    );

    // floor((2*v0 + v1 + v2) / 4) saturated, per-axis min and max
    always_comb
    begin
        logic signed [SUMW-1:0] s;
        logic signed [SUMW-1:0] q;
        logic signed [CW-1:0]   a, b, c, lo, hi;
        for (int i = 0; i < 3; i++)
        begin
            a = $signed(p0[i]);
            b = $signed(p1[i]);
            c = $signed(p2[i]);
            s = (SUMW'(a) <<< 1) + SUMW'(b) + SUMW'(c);
            q = s >>> 2;
            if (q > SUMW'($signed({1'b0, {(CW-1){1'b1}}})))
            begin
                side_next[i] = {1'b0, {(CW-1){1'b1}}};
            end
            else if (q < SUMW'($signed({1'b1, {(CW-1){1'b0}}})))
            begin
                side_next[i] = {1'b1, {(CW-1){1'b0}}};
            end
            else
            begin
                side_next[i] = q[CW-1:0];
            end
            lo = (a < b) ? a : b;
            hi = (a < b) ? b : a;
            if (c < lo)
            begin
                lo = c;
            end
            if (c > hi)
            begin
                hi = c;
            end
            side_next[3+i] = lo;
            side_next[6+i] = hi;
        end
    end

    // side delay line matched to the normal pipeline
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_next;
            for (int k = 1; k < LAT; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    // output register with skid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || !res_stall)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= div_valid;
            end
        end
        else if (div_valid && en)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || !res_stall)
        begin
            if (skid_valid_reg)
            begin
                out_nrm_reg  <= skid_nrm_reg;
                out_side_reg <= skid_side_reg;
            end
            else
            begin
                out_nrm_reg  <= div_normal;
                out_side_reg <= side_reg[LAT-1];
            end
        end
        else if (div_valid && en)
        begin
            skid_nrm_reg  <= div_normal;
            skid_side_reg <= side_reg[LAT-1];
        end
    end

    assign res_valid = out_valid_reg;
    assign ref_x     = out_side_reg[0];
    assign ref_y     = out_side_reg[1];
    assign ref_z     = out_side_reg[2];
    assign box_min_x = out_side_reg[3];
    assign box_min_y = out_side_reg[4];
    assign box_min_z = out_side_reg[5];
    assign box_max_x = out_side_reg[6];
    assign box_max_y = out_side_reg[7];
    assign box_max_z = out_side_reg[8];
    assign normal_x  = out_nrm_reg[0];
    assign normal_y  = out_nrm_reg[1];
    assign normal_z  = out_nrm_reg[2];

endmodule

[verif/tsnb_checker.sv]
module tsnb_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               tri_valid,
    input  logic               tri_stall,
    input  logic signed [31:0] vert0_x,
    input  logic signed [31:0] vert0_y,
    input  logic signed [31:0] vert0_z,
    input  logic signed [31:0] vert1_x,
    input  logic signed [31:0] vert1_y,
    input  logic signed [31:0] vert1_z,
    input  logic signed [31:0] vert2_x,
    input  logic signed [31:0] vert2_y,
    input  logic signed [31:0] vert2_z,
    input  logic               res_valid,
    input  logic               res_stall,
    input  logic signed [31:0] ref_x,
    input  logic signed [31:0] ref_y,
    input  logic signed [31:0] ref_z,
    input  logic signed [15:0] normal_x,
    input  logic signed [15:0] normal_y,
    input  logic signed [15:0] normal_z,
    input  logic signed [31:0] box_min_x,
    input  logic signed [31:0] box_min_y,
    input  logic signed [31:0] box_min_z,
    input  logic signed [31:0] box_max_x,
    input  logic signed [31:0] box_max_y,
    input  logic signed [31:0] box_max_z,
    output int                 fail_count,
    output int                 pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [2:0][31:0] refp;
        logic signed [2:0][15:0] nrm;
        logic signed [2:0][31:0] bmin;
        logic signed [2:0][31:0] bmax;
    } setup_t;

    setup_t setup_q[$];
    string axis_name[3] = '{"x", "y", "z"};

    // largest-magnitude bit length
    function automatic int bit_len(logic [127:0] v);
        int n;
        n = 0;
        for (int i = 0; i < 128; i++)
            if (v[i]) n = i + 1;
        return n;
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic setup_t predict_setup(logic signed [2:0][2:0][31:0] p);
        setup_t o;
        logic signed [63:0] ea[3], eb[3], s, q, lo, hi;
        logic signed [127:0] c[3];
        logic [127:0] mg[3];
        logic [63:0] m[3], sum, len, d;
        logic ng[3];
        int mx, sh;
        for (int i = 0; i < 3; i++)
        begin
            ea[i] = 64'($signed(p[1][i])) - 64'($signed(p[0][i]));
            eb[i] = 64'($signed(p[2][i])) - 64'($signed(p[0][i]));
            s = 4 * 64'($signed(p[0][i])) + ea[i] + eb[i];
            q = s >>> 2;
            if (q > 64'sd2147483647) q = 64'sd2147483647;
            if (q < -64'sd2147483648) q = -64'sd2147483648;
            o.refp[i] = q[31:0];
            lo = 64'($signed(p[0][i]));
            hi = 64'($signed(p[0][i]));
            for (int k = 1; k < 3; k++)
            begin
                if (64'($signed(p[k][i])) < lo) lo = 64'($signed(p[k][i]));
                if (64'($signed(p[k][i])) > hi) hi = 64'($signed(p[k][i]));
            end
            o.bmin[i] = lo[31:0];
            o.bmax[i] = hi[31:0];
        end
        // exact cross product
        c[0] = 128'(ea[1]) * 128'(eb[2]) - 128'(ea[2]) * 128'(eb[1]);
        c[1] = 128'(ea[2]) * 128'(eb[0]) - 128'(ea[0]) * 128'(eb[2]);
        c[2] = 128'(ea[0]) * 128'(eb[1]) - 128'(ea[1]) * 128'(eb[0]);
        mx = 0;
        for (int i = 0; i < 3; i++)
        begin
            ng[i] = c[i] < 0;
            mg[i] = ng[i] ? -c[i] : c[i];
            if (bit_len(mg[i]) > mx) mx = bit_len(mg[i]);
        end
        sh = mx > 30 ? mx - 30 : 0;
        sum = 0;
        for (int i = 0; i < 3; i++)
        begin
            m[i] = 64'(mg[i] >> sh);
            sum = sum + m[i] * m[i];
        end
        len = int_sqrt(sum);
        for (int i = 0; i < 3; i++)
        begin
            d = 0;
            if (len != 0)
            begin
                d = ((m[i] << 14) + len / 2) / len;
                if (d > 64'd16384) d = 64'd16384;
            end
            o.nrm[i] = ng[i] ? -16'(d) : 16'(d);
        end
        return o;
    endfunction

    // capture requests and check results
    always @(posedge clk)
    begin
        setup_t e, a;
        if (rst_n && tri_valid && !tri_stall)
            setup_q.insert(setup_q.size(), predict_setup({{vert2_z, vert2_y, vert2_x},
                {vert1_z, vert1_y, vert1_x}, {vert0_z, vert0_y, vert0_x}}));
        if (rst_n && res_valid && !res_stall)
        begin
            a.refp = {ref_z, ref_y, ref_x};
            a.nrm = {normal_z, normal_y, normal_x};
            a.bmin = {box_min_z, box_min_y, box_min_x};
            a.bmax = {box_max_z, box_max_y, box_max_x};
            if (setup_q.size() == 0)
            begin
                $error("result with no request outstanding");
                fail_count++;
            end
            else
            begin
                e = setup_q.pop_front();
                for (int i = 0; i < 3; i++)
                begin
                    if (a.refp[i] !== e.refp[i])
                    begin
                        $error("ref_%s exp %0d got %0d", axis_name[i],
                               $signed(e.refp[i]), $signed(a.refp[i]));
                        fail_count++;
                    end
                    if (a.nrm[i] !== e.nrm[i])
                    begin
                        $error("normal_%s exp %0d got %0d", axis_name[i],
                               $signed(e.nrm[i]), $signed(a.nrm[i]));
                        fail_count++;
                    end
                    if (a.bmin[i] !== e.bmin[i])
                    begin
                        $error("box_min_%s exp %0d got %0d", axis_name[i],
                               $signed(e.bmin[i]), $signed(a.bmin[i]));
                        fail_count++;
                    end
                    if (a.bmax[i] !== e.bmax[i])
                    begin
                        $error("box_max_%s exp %0d got %0d", axis_name[i],
                               $signed(e.bmax[i]), $signed(a.bmax[i]));
                        fail_count++;
                    end
                end
            end
        end
        pending <= setup_q.size();
    end

    initial
    begin
        fail_count = 0;
        pending = 0;
    end
endmodule

[verif/tb_triangle_setup_normal_bbox.sv]
module tb_triangle_setup_normal_bbox;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_RANDOM = 1250;

    logic clk, rst_n, tri_valid, tri_stall, res_valid, res_stall;
    logic signed [2:0][2:0][31:0] vert;
    logic signed [31:0] refp[3], bmin[3], bmax[3];
    logic signed [15:0] nrm[3];
    int fail_count, pending;
    bit quiet, hold_long;

    triangle_setup_normal_bbox i_dut (
        .clk(clk), .rst_n(rst_n), .tri_valid(tri_valid), .tri_stall(tri_stall),
        .vert0_x(vert[0][0]), .vert0_y(vert[0][1]), .vert0_z(vert[0][2]),
        .vert1_x(vert[1][0]), .vert1_y(vert[1][1]), .vert1_z(vert[1][2]),
        .vert2_x(vert[2][0]), .vert2_y(vert[2][1]), .vert2_z(vert[2][2]),
        .res_valid(res_valid), .res_stall(res_stall),
        .ref_x(refp[0]), .ref_y(refp[1]), .ref_z(refp[2]),
        .normal_x(nrm[0]), .normal_y(nrm[1]), .normal_z(nrm[2]),
        .box_min_x(bmin[0]), .box_min_y(bmin[1]), .box_min_z(bmin[2]),
        .box_max_x(bmax[0]), .box_max_y(bmax[1]), .box_max_z(bmax[2])
    );

    tsnb_checker i_checker (
        .clk(clk), .rst_n(rst_n), .tri_valid(tri_valid), .tri_stall(tri_stall),
        .vert0_x(vert[0][0]), .vert0_y(vert[0][1]), .vert0_z(vert[0][2]),
        .vert1_x(vert[1][0]), .vert1_y(vert[1][1]), .vert1_z(vert[1][2]),
        .vert2_x(vert[2][0]), .vert2_y(vert[2][1]), .vert2_z(vert[2][2]),
        .res_valid(res_valid), .res_stall(res_stall),
        .ref_x(refp[0]), .ref_y(refp[1]), .ref_z(refp[2]),
        .normal_x(nrm[0]), .normal_y(nrm[1]), .normal_z(nrm[2]),
        .box_min_x(bmin[0]), .box_min_y(bmin[1]), .box_min_z(bmin[2]),
        .box_max_x(bmax[0]), .box_max_y(bmax[1]), .box_max_z(bmax[2]),
        .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    // coordinate mix: extremes, small meshes, full random
    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'($urandom_range(0, 16)) - 32'd8;
            3, 4: return 32'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
            default: return $urandom();
        endcase
    endfunction

    // one request, held until accepted; valid stays up for the next one
    task automatic send_tri(logic signed [2:0][2:0][31:0] v);
        tri_valid <= 1'b1;
        vert <= v;
        @(posedge clk);
        while (tri_stall) @(posedge clk);
    endtask

    task automatic idle_gap();
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            tri_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    // receiver stall: bursts, one long hold-off
    initial
    begin
        res_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_long)
            begin
                res_stall <= 1'b1;
                repeat (150) @(posedge clk);
                hold_long = 0;
                res_stall <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 4) == 0)
            begin
                res_stall <= 1'b1;
                repeat ($urandom_range(1, 6) - 1) @(posedge clk);
            end
            else
                res_stall <= 1'b0;
        end
    end

    initial
    begin
        #4_000_000;
        $display("FAIL triangle_setup_normal_bbox");
        $finish;
    end

    initial
    begin
        logic signed [2:0][2:0][31:0] v;
        int waited;
        rst_n = 1'b0;
        tri_valid = 1'b0;
        vert = '0;
        quiet = 0;
        hold_long = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: degenerate, extremes, axis-aligned
        send_tri('0);
        v = '0; v[1][0] = 32'h0001_0000; v[2][1] = 32'h0001_0000;
        send_tri(v);
        v = '0; v[1][1] = 32'h0001_0000; v[2][2] = 32'h0001_0000;
        send_tri(v);
        v = '0; v[1][2] = 32'h0001_0000; v[2][0] = 32'h0001_0000;
        send_tri(v);
        send_tri({9{32'h7fff_ffff}});
        send_tri({9{32'h8000_0000}});
        v = {9{32'h7fff_ffff}}; v[0] = {3{32'h8000_0000}};
        send_tri(v);
        v = {9{32'h8000_0000}}; v[0] = {3{32'h7fff_ffff}};
        send_tri(v);
        v = '0; v[1] = {3{32'h7fff_ffff}}; v[2] = {3{32'h8000_0000}};
        send_tri(v);
        v = '0; v[1][0] = 32'h7fff_ffff; v[2][1] = 32'h7fff_ffff;
        send_tri(v);
        v = '0; v[0] = {3{32'h8000_0000}}; v[1][0] = 32'h7fff_ffff;
        v[2][1] = 32'h7fff_ffff;
        send_tri(v);
        v = '0; v[1] = {3{32'h0000_0001}}; v[2] = {3{32'h0000_0002}};
        send_tri(v);
        v = '0; v[1][0] = 1; v[2][1] = 1;
        send_tri(v);
        v = '0; v[0] = {3{32'hffff_ffff}}; v[1][2] = 32'h0000_0003;
        send_tri(v);

        // sender pause until drained
        tri_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0 || res_valid) @(posedge clk);

        for (int n = 0; n < NUM_RANDOM; n++)
        begin
            if (n == 300)
                hold_long = 1;
            if (n == NUM_RANDOM - 150)
                quiet = 1;
            foreach (v[k, i])
                v[k][i] = rand_coord();
            // repeated vertex gives a degenerate triangle
            if ($urandom_range(0, 15) == 0)
                v[2] = v[$urandom_range(0, 1)];
            send_tri(v);
            idle_gap();
        end
        tri_valid <= 1'b0;

        waited = 0;
        while ((pending != 0 || res_valid) && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (80) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("PASS triangle_setup_normal_bbox");
        else
            $display("FAIL triangle_setup_normal_bbox");
        $finish;
    end
endmodule
